>>> hdl/humidity_temp_frame_checker_macros.svh
// Assertion macros shared by the sensor reply checker.
// Each macro takes a label, the clock, the active-low reset and two
// expressions.
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define HFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define HFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor reply
// checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned TC_W   = 15;
    localparam int unsigned HC_W   = 14;

    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // Byte positions within one reply
    localparam logic [POS_W-1:0] POS_T_HI   = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LO   = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC  = 3'd2;
    localparam logic [POS_W-1:0] POS_H_HI   = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LO   = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC  = 3'd5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TEMP_CRC  = 2'd1,
        ST_HUM_CRC   = 2'd2,
        ST_BUS_FAULT = 2'd3
    } t_status;

    // Frame decoder result toward the output stage
    typedef struct packed {
        logic              emit;
        t_status           status;
        logic [WORD_W-1:0] raw_t;
        logic [WORD_W-1:0] raw_h;
    } t_frame_res;

    // CRC-8, MSB first, no reflection, no final XOR
    function automatic logic [BYTE_W-1:0] crc8_byte(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[BYTE_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> hdl/hfc_frame.sv
// ----------------------------------------------------------------------------
// hfc_frame
// Byte position tracking, CRC-8 checking and word assembly for one reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfc_frame (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [hfc_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                       i_start,
    input  wire logic                       i_fault,
    output hfc_pkg::t_frame_res             o_res
);
    import hfc_pkg::*;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [BYTE_W-1:0] r_crc,   n_crc;
    logic [WORD_W-1:0] r_t_word, n_t_word;
    logic [WORD_W-1:0] r_h_word, n_h_word;
    logic              r_t_bad, n_t_bad;
    logic [POS_W-1:0]  w_pos;
    logic [BYTE_W-1:0] w_crc_upd;

    // Pick the effective position: start flag or an unused code restarts
    always_comb begin
        w_pos = i_start ? POS_T_HI : r_pos;
        if (w_pos > POS_H_CRC) begin
            w_pos = POS_T_HI;
        end
    end

    // Seed the CRC with its initial value on the high byte of each word
    assign w_crc_upd = crc8_byte(((w_pos == POS_T_HI) || (w_pos == POS_H_HI))
                                 ? CRC_INIT : r_crc, i_byte);

    // Decode the current word and compute the next frame state
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_t_word = r_t_word;
        n_h_word = r_h_word;
        n_t_bad  = r_t_bad;
        o_res.emit   = 1'b0;
        o_res.status = ST_OK;
        o_res.raw_t  = r_t_word;
        o_res.raw_h  = r_h_word;
        if (i_fault) begin
            n_pos        = POS_T_HI;
            n_crc        = CRC_INIT;
            o_res.emit   = 1'b1;
            o_res.status = ST_BUS_FAULT;
            o_res.raw_t  = '0;
            o_res.raw_h  = '0;
        end else begin
            case (w_pos)
                POS_T_HI: begin
                    n_crc    = w_crc_upd;
                    n_t_word = {i_byte, 8'h00};
                    n_pos    = POS_T_LO;
                end
                POS_T_LO: begin
                    n_crc    = w_crc_upd;
                    n_t_word = {r_t_word[WORD_W-1:BYTE_W], i_byte};
                    n_pos    = POS_T_CRC;
                end
                POS_T_CRC: begin
                    n_t_bad = (r_crc != i_byte);
                    n_crc   = CRC_INIT;
                    n_pos   = POS_H_HI;
                end
                POS_H_HI: begin
                    n_crc    = w_crc_upd;
                    n_h_word = {i_byte, 8'h00};
                    n_pos    = POS_H_LO;
                end
                POS_H_LO: begin
                    n_crc    = w_crc_upd;
                    n_h_word = {r_h_word[WORD_W-1:BYTE_W], i_byte};
                    n_pos    = POS_H_CRC;
                end
                default: begin
                    n_crc      = CRC_INIT;
                    n_pos      = POS_T_HI;
                    o_res.emit = 1'b1;
                    if (r_t_bad) begin
                        o_res.status = ST_TEMP_CRC;
                    end else if (r_crc != i_byte) begin
                        o_res.status = ST_HUM_CRC;
                    end else begin
                        o_res.status = ST_OK;
                    end
                end
            endcase
        end
    end

    // Advance the frame state when the held word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_T_HI;
            r_crc    <= CRC_INIT;
            r_t_word <= '0;
            r_h_word <= '0;
            r_t_bad  <= 1'b0;
        end else if (i_adv) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_t_word <= n_t_word;
            r_h_word <= n_h_word;
            r_t_bad  <= n_t_bad;
        end
    end

endmodule

`default_nettype wire

>>> hdl/hfc_scale.sv
// ----------------------------------------------------------------------------
// hfc_scale
// Floored scaling of the raw words to hundredths of a degree and of a percent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfc_scale (
    input  wire logic [hfc_pkg::WORD_W-1:0]      i_raw_t,
    input  wire logic [hfc_pkg::WORD_W-1:0]      i_raw_h,
    output logic signed [hfc_pkg::TC_W-1:0]      o_temp_centi,
    output logic [hfc_pkg::HC_W-1:0]             o_hum_centi
);
    import hfc_pkg::*;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;

    logic [30:0] w_t_prod;
    logic [31:0] w_t_sum;
    logic [14:0] w_t_q;
    logic [29:0] w_h_prod;
    logic [30:0] w_h_sum;

    // Divide by 65535 exactly: q = (p + (p >> 16) + 1) >> 16 while q < 2^16
    assign w_t_prod = 31'(TEMP_SPAN) * 31'(i_raw_t);
    assign w_t_sum  = 32'(w_t_prod) + 32'(w_t_prod[30:16]) + 32'd1;
    assign w_t_q    = w_t_sum[30:16];
    assign o_temp_centi = signed'(w_t_q - TEMP_OFFSET);

    assign w_h_prod = 30'(HUM_SPAN) * 30'(i_raw_h);
    assign w_h_sum  = 31'(w_h_prod) + 31'(w_h_prod[29:16]) + 31'd1;
    assign o_hum_centi = w_h_sum[29:16];

endmodule

`default_nettype wire

>>> hdl/humidity_temp_frame_checker.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Checks and converts the six-byte humidity/temperature sensor reply.
// ----------------------------------------------------------------------------
// The block takes one reply byte per word on the slave side and accepts a
// word in every cycle unless a result waits on a stalled master side. A
// word passes the input register, where the CRC-8 update, byte position
// decode and constant scaling run, then the result register. A stalled
// master side holds the result register; the input register still drains
// words that give no result, so throughput is one byte per cycle while
// results are taken.
// Status codes: 0 ok, 1 temperature CRC bad (wins), 2 humidity CRC bad,
// 3 bus fault (all value fields zero). Scaled values are zero unless ok.
`timescale 1ns / 1ps
`default_nettype none

`include "humidity_temp_frame_checker_macros.svh"

module humidity_temp_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] frame_start, [1] bus_fault
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [15:0] raw_temperature,
                                             // [31:16] raw_humidity,
                                             // [46:32] temperature_centi,
                                             // [60:47] humidity_centi, zero pad
    output logic [1:0]       m_axis_tuser    // [1:0] status
);
    import hfc_pkg::*;

    logic                     r_in_valid;
    logic [BYTE_W-1:0]        r_in_byte;
    logic                     r_in_start;
    logic                     r_in_fault;
    logic                     r_out_valid;
    t_status                  r_status;
    logic [WORD_W-1:0]        r_raw_t;
    logic [WORD_W-1:0]        r_raw_h;
    logic signed [TC_W-1:0]   r_temp_centi;
    logic [HC_W-1:0]          r_hum_centi;
    logic                     w_out_free;
    logic                     w_in_adv;
    t_frame_res               w_res;
    logic signed [TC_W-1:0]   w_temp_centi;
    logic [HC_W-1:0]          w_hum_centi;
    logic                     w_out_fault;
    logic                     w_out_err;
    logic                     w_raw_zero;
    logic                     w_scaled_zero;
    logic                     w_in_stall;

    // Handshake: the held word moves on unless its result finds no room
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_in_adv      = r_in_valid && (!w_res.emit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_in_adv;

    // Hold the accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
            r_in_fault <= s_axis_tuser[1];
        end
    end

    hfc_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_in_adv),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .i_fault (r_in_fault),
        .o_res   (w_res)
    );

    hfc_scale u_scale (
        .i_raw_t      (w_res.raw_t),
        .i_raw_h      (w_res.raw_h),
        .o_temp_centi (w_temp_centi),
        .o_hum_centi  (w_hum_centi)
    );

    // Load the result register; scaled values only for a clean frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_in_adv && w_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_in_adv && w_res.emit) begin
            r_status     <= w_res.status;
            r_raw_t      <= w_res.raw_t;
            r_raw_h      <= w_res.raw_h;
            r_temp_centi <= (w_res.status == ST_OK) ? w_temp_centi : '0;
            r_hum_centi  <= (w_res.status == ST_OK) ? w_hum_centi : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_hum_centi, r_temp_centi, r_raw_h, r_raw_t};

    // Checks on the result stage
    assign w_out_fault   = r_out_valid && (r_status == ST_BUS_FAULT);
    assign w_out_err     = r_out_valid && (r_status != ST_OK);
    assign w_raw_zero    = (r_raw_t == '0) && (r_raw_h == '0);
    assign w_scaled_zero = (r_temp_centi == '0) && (r_hum_centi == '0);
    assign w_in_stall    = r_in_valid && !w_in_adv;

    `HFC_ASSERT_IMPL(a_fault_zero, i_clk, i_rst_n, w_out_fault, w_raw_zero && w_scaled_zero)
    `HFC_ASSERT_IMPL(a_bad_no_scale, i_clk, i_rst_n, w_out_err, w_scaled_zero)
    `HFC_ASSERT_IMPL(a_hum_range, i_clk, i_rst_n, r_out_valid, r_hum_centi <= 14'd10000)
    `HFC_ASSERT_NEXT(a_stall_hold_in, i_clk, i_rst_n, w_in_stall, r_in_valid && $stable(r_in_byte))

endmodule

`default_nettype wire
